>>> hw/rtl/ndvrp_pkg.sv
// shared types, constants and helpers for the n-d vertex rotate / project block
package ndvrp_pkg;

  localparam int NUM_COORDS = 8;
  localparam int COORD_W    = 18;
  localparam int SCREEN_W   = 24;
  localparam int TRIG_W     = 16;
  localparam int TRIG_FRAC  = 14;
  localparam int DIM_W      = 4;
  localparam int BASE_W     = 8;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int ROT_W      = COORD_W + TRIG_W + 1;

  localparam int MAX_DIMENSION_DEF   = 8;
  localparam int COORD_FRAC_BITS_DEF = 14;

  localparam logic [CFG_IDX_W-1:0] REG_DIM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd3;

  localparam logic CMD_ROTATE  = 1'b0;
  localparam logic CMD_PROJECT = 1'b1;

  localparam logic [DIM_W-1:0]  DIM_RESET  = 4'd3;
  localparam logic [TRIG_W-1:0] COS_RESET  = 16'd16384;
  localparam logic [TRIG_W-1:0] SIN_RESET  = 16'd0;
  localparam logic [BASE_W-1:0] BASE_RESET = 8'd10;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [SCREEN_W-1:0] scr_t;

  typedef struct packed {
    logic                        valid;
    logic                        cmd;
    coord_t [NUM_COORDS-1:0]     v;
  } rot_item_t;

  typedef struct packed {
    logic                        valid;
    logic                        cmd;
    coord_t [NUM_COORDS-1:0]     v;
    scr_t   [NUM_COORDS-1:0]     w;
  } proj_item_t;

  // clamp a wide rotation sum into the coordinate range
  function automatic coord_t sat_coord(input logic [ROT_W-1:0] x);
    coord_t r;
    if (!x[ROT_W-1] && (|x[ROT_W-2:COORD_W-1])) begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (x[ROT_W-1] && !(&x[ROT_W-2:COORD_W-1])) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = x[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/ndvrp_rot_cell.sv
// one rotation cell: rotates a single axis plane for rotate items within the dimension and registers the vertex
module ndvrp_rot_cell #(
  parameter int PLANE = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [ndvrp_pkg::TRIG_W-1:0] cos_value,
  input  logic signed [ndvrp_pkg::TRIG_W-1:0] sin_value,
  input  logic [ndvrp_pkg::DIM_W-1:0]         dim,
  input  ndvrp_pkg::rot_item_t                in_item,
  output ndvrp_pkg::rot_item_t                out_item
);

  localparam int PROD_W = ndvrp_pkg::COORD_W + ndvrp_pkg::TRIG_W;

  logic signed [ndvrp_pkg::COORD_W-1:0] a, b;
  logic signed [PROD_W-1:0]             ac, bs, as, bc;
  logic signed [ndvrp_pkg::ROT_W-1:0]   p, q;
  logic [ndvrp_pkg::ROT_W-1:0]          ps, qs;
  logic                                 active;
  ndvrp_pkg::coord_t [ndvrp_pkg::NUM_COORDS-1:0] v_next;

  always_comb begin
    a  = in_item.v[PLANE];
    b  = in_item.v[PLANE+1];
    ac = a * cos_value;
    bs = b * sin_value;
    as = a * sin_value;
    bc = b * cos_value;
    // round half up, then floor shift
    p  = ndvrp_pkg::ROT_W'(ac) - ndvrp_pkg::ROT_W'(bs)
         + ndvrp_pkg::ROT_W'(1 << (ndvrp_pkg::TRIG_FRAC - 1));
    q  = ndvrp_pkg::ROT_W'(as) + ndvrp_pkg::ROT_W'(bc)
         + ndvrp_pkg::ROT_W'(1 << (ndvrp_pkg::TRIG_FRAC - 1));
    ps = p >>> ndvrp_pkg::TRIG_FRAC;
    qs = q >>> ndvrp_pkg::TRIG_FRAC;
    active = (in_item.cmd == ndvrp_pkg::CMD_ROTATE) &&
             (dim > ndvrp_pkg::DIM_W'(PLANE + 1));
    v_next = in_item.v;
    if (active) begin
      v_next[PLANE]   = ndvrp_pkg::sat_coord(ps);
      v_next[PLANE+1] = ndvrp_pkg::sat_coord(qs);
    end
  end

  always_ff @(posedge clk) begin
    out_item.cmd <= in_item.cmd;
    out_item.v   <= v_next;
    if (rst) begin
      out_item.valid <= 1'b0;
    end else begin
      out_item.valid <= in_item.valid;
    end
  end

endmodule

>>> hw/rtl/ndvrp_div_lane.sv
// pipelined restoring divider lane, one quotient bit per stage, saturating result
module ndvrp_div_lane #(
  parameter int NUM_W = 50,
  parameter int DEN_W = 28
) (
  input  logic                                 clk,
  input  logic [NUM_W-1:0]                     num,
  input  logic [DEN_W-1:0]                     den_mag,
  input  logic                                 neg,
  output logic signed [ndvrp_pkg::SCREEN_W-1:0] res
);

  localparam int QW   = ndvrp_pkg::SCREEN_W;
  localparam int HI_W = NUM_W - QW;

  logic [DEN_W-1:0] rem  [0:QW];
  logic [QW-1:0]    quo  [0:QW];
  logic [QW-1:0]    nlo  [0:QW];
  logic [DEN_W-1:0] den  [0:QW];
  logic             sgn  [0:QW];
  logic             ovf  [0:QW];
  logic [DEN_W-1:0] hi_ext;

  // quotient must fit in QW bits, otherwise flag overflow
  always_comb begin
    hi_ext = {{(DEN_W-HI_W){1'b0}}, num[NUM_W-1:QW]};
  end

  always_ff @(posedge clk) begin
    rem[0] <= hi_ext;
    quo[0] <= '0;
    nlo[0] <= num[QW-1:0];
    den[0] <= den_mag;
    sgn[0] <= neg;
    ovf[0] <= (hi_ext >= den_mag);
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DEN_W:0] trial, diff;
    logic           ge;
    always_comb begin
      trial = {rem[k-1], nlo[k-1][QW-k]};
      diff  = trial - {1'b0, den[k-1]};
      ge    = (trial >= {1'b0, den[k-1]});
    end
    always_ff @(posedge clk) begin
      rem[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo[k] <= {quo[k-1][QW-2:0], ge};
      nlo[k] <= nlo[k-1];
      den[k] <= den[k-1];
      sgn[k] <= sgn[k-1];
      ovf[k] <= ovf[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (sgn[QW]) begin
      if (ovf[QW] || (quo[QW][QW-1] && (|quo[QW][QW-2:0]))) begin
        res <= {1'b1, {(QW-1){1'b0}}};
      end else begin
        res <= -$signed(quo[QW]);
      end
    end else begin
      if (ovf[QW] || quo[QW][QW-1]) begin
        res <= {1'b0, {(QW-1){1'b1}}};
      end else begin
        res <= $signed(quo[QW]);
      end
    end
  end

endmodule

>>> hw/rtl/ndvrp_proj_level.sv
// one projection level: divides the leading coordinates by the level's denominator
module ndvrp_proj_level #(
  parameter int LEVEL           = 3,
  parameter int COORD_FRAC_BITS = 14,
  parameter int LVL_W           = 4,
  parameter int DIST_W          = 26,
  parameter int DEN_W           = 28,
  parameter int NUM_W           = 50
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ndvrp_pkg::BASE_W-1:0] d_prime_base,
  input  logic [ndvrp_pkg::DIM_W-1:0]  dim,
  input  ndvrp_pkg::proj_item_t       in_item,
  output ndvrp_pkg::proj_item_t       out_item
);

  localparam int NL    = LEVEL - 1;
  localparam int UW    = ndvrp_pkg::BASE_W + LVL_W;
  localparam int SW    = ndvrp_pkg::SCREEN_W;
  localparam int DEPTH = SW + 2;

  logic [UW-1:0]           units;
  logic [DIST_W-1:0]       distance;
  logic signed [DEN_W-1:0] den;
  logic [DEN_W-1:0]        den_mag;
  logic                    active;

  logic [NUM_W-1:0] num_a   [0:NL-1];
  logic             neg_a   [0:NL-1];
  logic [DEN_W-1:0] den_a;
  logic             act     [0:DEPTH];
  ndvrp_pkg::proj_item_t side [0:DEPTH];
  ndvrp_pkg::scr_t  lane_res [0:NL-1];

  always_comb begin
    units    = UW'(d_prime_base) * UW'(LEVEL);
    distance = {units, {COORD_FRAC_BITS{1'b0}}};
    den      = $signed({{(DEN_W-DIST_W){1'b0}}, distance})
               + $signed({{(DEN_W-SW){in_item.w[LEVEL-1][SW-1]}}, in_item.w[LEVEL-1]});
    if (den == '0) begin
      den = '1;
    end
    den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    active  = (in_item.cmd == ndvrp_pkg::CMD_PROJECT) && (dim >= ndvrp_pkg::DIM_W'(LEVEL));
  end

  for (genvar i = 0; i < NL; i++) begin : g_lane
    logic [SW-1:0] wmag;
    always_comb begin
      wmag = in_item.w[i][SW-1] ? SW'(-in_item.w[i]) : SW'(in_item.w[i]);
    end
    always_ff @(posedge clk) begin
      num_a[i] <= NUM_W'(wmag) * NUM_W'(distance);
      neg_a[i] <= in_item.w[i][SW-1] ^ den[DEN_W-1];
    end
    ndvrp_div_lane #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
    ) u_lane (
      .clk     (clk),
      .num     (num_a[i]),
      .den_mag (den_a),
      .neg     (neg_a[i]),
      .res     (lane_res[i])
    );
  end

  always_ff @(posedge clk) begin
    den_a       <= den_mag;
    act[0]      <= active;
    side[0].cmd <= in_item.cmd;
    side[0].v   <= in_item.v;
    side[0].w   <= in_item.w;
    if (rst) begin
      side[0].valid <= 1'b0;
    end else begin
      side[0].valid <= in_item.valid;
    end
  end

  // side chain keeps the vertex alongside the divider lanes
  for (genvar k = 1; k <= DEPTH; k++) begin : g_side
    always_ff @(posedge clk) begin
      act[k]      <= act[k-1];
      side[k].cmd <= side[k-1].cmd;
      side[k].v   <= side[k-1].v;
      side[k].w   <= side[k-1].w;
      if (rst) begin
        side[k].valid <= 1'b0;
      end else begin
        side[k].valid <= side[k-1].valid;
      end
    end
  end

  always_comb begin
    out_item = side[DEPTH];
    if (act[DEPTH]) begin
      for (int i = 0; i < NL; i++) begin
        out_item.w[i] = lane_res[i];
      end
    end
  end

endmodule

>>> hw/rtl/nd_vertex_rotate_project.sv
// top level of the n-d vertex rotate / perspective project block
// One vertex of up to eight signed Q3.14 coordinates enters per clock with
// start while busy is low; busy is high in reset and the cycle after. Every
// item gives exactly one result, shown for one cycle with done, in the order
// taken; the receiver cannot stall, so results must be captured when done is
// high. The path runs through the input register, the row of rotation cells
// (one plane per cell), the row of projection levels, each a 27-stage
// pipeline whose divider lanes resolve one quotient bit per stage, and the
// output register. Throughput is one item per cycle for rotate and project
// mixed freely. Configuration registers are written through the cfg port
// (index 0 dimension, 1 cosine, 2 sine, 3 base distance) and must only change
// while no item is in flight.
module nd_vertex_rotate_project #(
  parameter int MAX_DIMENSION   = ndvrp_pkg::MAX_DIMENSION_DEF,
  parameter int COORD_FRAC_BITS = ndvrp_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // item channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  command,
  input  logic signed [ndvrp_pkg::COORD_W-1:0]  coord_0,
  input  logic signed [ndvrp_pkg::COORD_W-1:0]  coord_1,
  input  logic signed [ndvrp_pkg::COORD_W-1:0]  coord_2,
  input  logic signed [ndvrp_pkg::COORD_W-1:0]  coord_3,
  input  logic signed [ndvrp_pkg::COORD_W-1:0]  coord_4,
  input  logic signed [ndvrp_pkg::COORD_W-1:0]  coord_5,
  input  logic signed [ndvrp_pkg::COORD_W-1:0]  coord_6,
  input  logic signed [ndvrp_pkg::COORD_W-1:0]  coord_7,
  // config channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ndvrp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ndvrp_pkg::CFG_W-1:0]           cfg_data,
  // result channel
  output logic                                  done,
  output logic signed [ndvrp_pkg::COORD_W-1:0]  rot_0,
  output logic signed [ndvrp_pkg::COORD_W-1:0]  rot_1,
  output logic signed [ndvrp_pkg::COORD_W-1:0]  rot_2,
  output logic signed [ndvrp_pkg::COORD_W-1:0]  rot_3,
  output logic signed [ndvrp_pkg::COORD_W-1:0]  rot_4,
  output logic signed [ndvrp_pkg::COORD_W-1:0]  rot_5,
  output logic signed [ndvrp_pkg::COORD_W-1:0]  rot_6,
  output logic signed [ndvrp_pkg::COORD_W-1:0]  rot_7,
  output logic signed [ndvrp_pkg::SCREEN_W-1:0] screen_x,
  output logic signed [ndvrp_pkg::SCREEN_W-1:0] screen_y
);

  // derived widths for the projection datapath
  localparam int LVL_W  = $clog2(MAX_DIMENSION + 1);
  localparam int DIST_W = ndvrp_pkg::BASE_W + LVL_W + COORD_FRAC_BITS;
  localparam int DEN_W  = ((DIST_W > ndvrp_pkg::SCREEN_W) ? DIST_W : ndvrp_pkg::SCREEN_W) + 2;
  localparam int NUM_W  = ndvrp_pkg::SCREEN_W + DIST_W;
  localparam int NROT   = MAX_DIMENSION - 1;
  localparam int NLVL   = MAX_DIMENSION - 2;
  localparam int NC     = ndvrp_pkg::NUM_COORDS;

  // configuration registers
  logic [ndvrp_pkg::DIM_W-1:0]         dimension_in_use;
  logic signed [ndvrp_pkg::TRIG_W-1:0] cos_value;
  logic signed [ndvrp_pkg::TRIG_W-1:0] sin_value;
  logic [ndvrp_pkg::BASE_W-1:0]        d_prime_base;
  logic [ndvrp_pkg::DIM_W-1:0]         dim_eff;

  logic running;
  logic accept;
  logic out_cmd;

  ndvrp_pkg::rot_item_t  entry;
  ndvrp_pkg::rot_item_t  rchain [0:NROT];
  ndvrp_pkg::proj_item_t pchain [0:NLVL];

  assign busy      = !running;
  assign cfg_ready = running;
  assign accept    = start && !busy;

  // dimension beyond the maximum acts as the maximum
  assign dim_eff = (dimension_in_use > ndvrp_pkg::DIM_W'(MAX_DIMENSION))
                   ? ndvrp_pkg::DIM_W'(MAX_DIMENSION) : dimension_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      running          <= 1'b0;
      dimension_in_use <= ndvrp_pkg::DIM_RESET;
      cos_value        <= ndvrp_pkg::COS_RESET;
      sin_value        <= ndvrp_pkg::SIN_RESET;
      d_prime_base     <= ndvrp_pkg::BASE_RESET;
    end else begin
      running <= 1'b1;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ndvrp_pkg::REG_DIM:  dimension_in_use <= cfg_data[ndvrp_pkg::DIM_W-1:0];
          ndvrp_pkg::REG_COS:  cos_value        <= cfg_data[ndvrp_pkg::TRIG_W-1:0];
          ndvrp_pkg::REG_SIN:  sin_value        <= cfg_data[ndvrp_pkg::TRIG_W-1:0];
          ndvrp_pkg::REG_BASE: d_prime_base     <= cfg_data[ndvrp_pkg::BASE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    entry.cmd  <= command;
    entry.v[0] <= coord_0;
    entry.v[1] <= coord_1;
    entry.v[2] <= coord_2;
    entry.v[3] <= coord_3;
    entry.v[4] <= coord_4;
    entry.v[5] <= coord_5;
    entry.v[6] <= coord_6;
    entry.v[7] <= coord_7;
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= accept;
    end
  end

  assign rchain[0] = entry;

  // rotation row: plane k rotates axes k and k+1 using the previous cell's output
  for (genvar k = 0; k < NROT; k++) begin : g_rot
    ndvrp_rot_cell #(
      .PLANE (k)
    ) u_rot (
      .clk       (clk),
      .rst       (rst),
      .cos_value (cos_value),
      .sin_value (sin_value),
      .dim       (dim_eff),
      .in_item   (rchain[k]),
      .out_item  (rchain[k+1])
    );
  end

  // working coordinates widen to the screen format for projection
  always_comb begin
    pchain[0].valid = rchain[NROT].valid;
    pchain[0].cmd   = rchain[NROT].cmd;
    pchain[0].v     = rchain[NROT].v;
    for (int i = 0; i < NC; i++) begin
      pchain[0].w[i] = ndvrp_pkg::SCREEN_W'(rchain[NROT].v[i]);
    end
  end

  // projection row: highest level first, down to level three
  for (genvar j = 0; j < NLVL; j++) begin : g_lvl
    ndvrp_proj_level #(
      .LEVEL           (MAX_DIMENSION - j),
      .COORD_FRAC_BITS (COORD_FRAC_BITS),
      .LVL_W           (LVL_W),
      .DIST_W          (DIST_W),
      .DEN_W           (DEN_W),
      .NUM_W           (NUM_W)
    ) u_lvl (
      .clk          (clk),
      .rst          (rst),
      .d_prime_base (d_prime_base),
      .dim          (dim_eff),
      .in_item      (pchain[j]),
      .out_item     (pchain[j+1])
    );
  end

  // output register: rotated or copied coordinates plus the screen point
  always_ff @(posedge clk) begin
    out_cmd  <= pchain[NLVL].cmd;
    rot_0    <= pchain[NLVL].v[0];
    rot_1    <= pchain[NLVL].v[1];
    rot_2    <= pchain[NLVL].v[2];
    rot_3    <= pchain[NLVL].v[3];
    rot_4    <= pchain[NLVL].v[4];
    rot_5    <= pchain[NLVL].v[5];
    rot_6    <= pchain[NLVL].v[6];
    rot_7    <= pchain[NLVL].v[7];
    screen_x <= (pchain[NLVL].cmd == ndvrp_pkg::CMD_PROJECT) ? pchain[NLVL].w[0] : '0;
    screen_y <= ((pchain[NLVL].cmd == ndvrp_pkg::CMD_PROJECT) &&
                 (dim_eff >= ndvrp_pkg::DIM_W'(2))) ? pchain[NLVL].w[1] : '0;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pchain[NLVL].valid;
    end
  end

  // rotate results never carry a screen point
  a_rot_screen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (out_cmd == ndvrp_pkg::CMD_ROTATE)) |-> (screen_x == '0) && (screen_y == '0))
    else $error("screen point nonzero on a rotate result");

  // reset flushes the entry stage and the result strobe
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done && !entry.valid)
    else $error("pipeline not flushed by reset");

  // an accepted item always lands in the entry stage
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    accept |=> entry.valid)
    else $error("accepted item lost at entry");

  // busy is high and the config port is closed right after reset
  a_busy_after_reset: assert property (@(posedge clk)
    rst |=> busy && !cfg_ready)
    else $error("block open right after reset");

endmodule

>>> bench/nd_vertex_rotate_project_tb.sv
// self-checking bench for the n-d vertex rotate / perspective project block
module nd_vertex_rotate_project_tb;

  // vertex entering the block and the full result it should produce
  typedef struct {
    logic              cmd;
    ndvrp_pkg::coord_t c [ndvrp_pkg::NUM_COORDS];
  } vertex_t;

  typedef struct {
    ndvrp_pkg::coord_t rot [ndvrp_pkg::NUM_COORDS];
    ndvrp_pkg::scr_t   sx;
    ndvrp_pkg::scr_t   sy;
  } vertex_result_t;

  localparam int LATENCY   = 2 + (ndvrp_pkg::MAX_DIMENSION_DEF - 1)
                             + (ndvrp_pkg::MAX_DIMENSION_DEF - 2) * 27;
  localparam int CYCLE_CAP = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic command = ndvrp_pkg::CMD_ROTATE;
  ndvrp_pkg::coord_t coord_in [ndvrp_pkg::NUM_COORDS];
  logic cfg_valid = 1'b0;
  logic [ndvrp_pkg::CFG_IDX_W-1:0] cfg_index = ndvrp_pkg::REG_DIM;
  logic [ndvrp_pkg::CFG_W-1:0] cfg_data = '0;
  logic busy, cfg_ready, done;
  ndvrp_pkg::coord_t rot_out [ndvrp_pkg::NUM_COORDS];
  ndvrp_pkg::scr_t screen_x, screen_y;

  // shadow copy of the configuration registers
  logic [ndvrp_pkg::DIM_W-1:0]  dim_reg  = ndvrp_pkg::DIM_RESET;
  logic [ndvrp_pkg::TRIG_W-1:0] cos_reg  = ndvrp_pkg::COS_RESET;
  logic [ndvrp_pkg::TRIG_W-1:0] sin_reg  = ndvrp_pkg::SIN_RESET;
  logic [ndvrp_pkg::BASE_W-1:0] base_reg = ndvrp_pkg::BASE_RESET;

  vertex_t        pending_vertices [$];
  vertex_result_t expected_results [$];
  int error_count = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  int gap_left    = 0;

  initial for (int i = 0; i < ndvrp_pkg::NUM_COORDS; i++) coord_in[i] = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  nd_vertex_rotate_project dut (
    .clk, .rst, .start, .busy, .command,
    .coord_0(coord_in[0]), .coord_1(coord_in[1]), .coord_2(coord_in[2]),
    .coord_3(coord_in[3]), .coord_4(coord_in[4]), .coord_5(coord_in[5]),
    .coord_6(coord_in[6]), .coord_7(coord_in[7]),
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .done,
    .rot_0(rot_out[0]), .rot_1(rot_out[1]), .rot_2(rot_out[2]),
    .rot_3(rot_out[3]), .rot_4(rot_out[4]), .rot_5(rot_out[5]),
    .rot_6(rot_out[6]), .rot_7(rot_out[7]),
    .screen_x, .screen_y
  );

  function automatic longint clamp_to(longint x, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -(longint'(1) <<< (w - 1));
    return (x > hi) ? hi : ((x < lo) ? lo : x);
  endfunction

  // rotate plane by plane or divide level by level, using the shadow registers
  function automatic vertex_result_t transform_vertex(vertex_t vx);
    vertex_result_t r;
    longint v [ndvrp_pkg::NUM_COORDS];
    longint c, s, p, q, distance, den;
    int d;
    d = (dim_reg > ndvrp_pkg::MAX_DIMENSION_DEF) ? ndvrp_pkg::MAX_DIMENSION_DEF
                                                 : int'(dim_reg);
    for (int i = 0; i < ndvrp_pkg::NUM_COORDS; i++) v[i] = vx.c[i];
    r.sx = '0;
    r.sy = '0;
    if (vx.cmd == ndvrp_pkg::CMD_ROTATE) begin
      c = longint'($signed(cos_reg));
      s = longint'($signed(sin_reg));
      for (int i = 0; i + 1 < d; i++) begin
        p = v[i] * c - v[i+1] * s;
        q = v[i] * s + v[i+1] * c;
        // arithmetic shift gives floor, so this rounds ties upward
        v[i]   = clamp_to((p + (1 <<< (ndvrp_pkg::TRIG_FRAC - 1))) >>> ndvrp_pkg::TRIG_FRAC,
                          ndvrp_pkg::COORD_W);
        v[i+1] = clamp_to((q + (1 <<< (ndvrp_pkg::TRIG_FRAC - 1))) >>> ndvrp_pkg::TRIG_FRAC,
                          ndvrp_pkg::COORD_W);
      end
      for (int i = 0; i < ndvrp_pkg::NUM_COORDS; i++) r.rot[i] = ndvrp_pkg::coord_t'(v[i]);
    end else begin
      for (int i = 0; i < ndvrp_pkg::NUM_COORDS; i++) r.rot[i] = vx.c[i];
      for (int lvl = d; lvl > 2; lvl--) begin
        distance = longint'(base_reg) * lvl <<< ndvrp_pkg::COORD_FRAC_BITS_DEF;
        den      = distance + v[lvl-1];
        if (den == 0) den = -1;
        // integer division truncates toward zero
        for (int i = 0; i + 1 < lvl; i++)
          v[i] = clamp_to((v[i] * distance) / den, ndvrp_pkg::SCREEN_W);
      end
      r.sx = ndvrp_pkg::scr_t'(v[0]);
      r.sy = (d >= 2) ? ndvrp_pkg::scr_t'(v[1]) : '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // driver: bursts with random gaps, inputs change on the falling edge
  always @(negedge clk) begin
    if (start && !busy && !rst) begin
      // the previous item went in at the last rising edge
    end
    if (!rst && !(start && busy)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_vertices.size() > 0) begin
        vertex_t vx;
        vx = pending_vertices.pop_front();
        expected_results.insert(expected_results.size(), transform_vertex(vx));
        command <= vx.cmd;
        for (int i = 0; i < ndvrp_pkg::NUM_COORDS; i++) coord_in[i] <= vx.c[i];
        start <= 1'b1;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 12);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results are taken at the rising edge that ends the done cycle
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", 1, 0);
      end else begin
        vertex_result_t e;
        e = expected_results.pop_front();
        for (int i = 0; i < ndvrp_pkg::NUM_COORDS; i++)
          if (rot_out[i] !== e.rot[i])
            report_mismatch($sformatf("rot_%0d", i), rot_out[i], e.rot[i]);
        if (screen_x !== e.sx) report_mismatch("screen_x", screen_x, e.sx);
        if (screen_y !== e.sy) report_mismatch("screen_y", screen_y, e.sy);
      end
    end
    if (cycle_count > CYCLE_CAP) begin
      $display("[nd_vertex_rotate_project] ERROR");
      $finish;
    end
  end

  function automatic ndvrp_pkg::coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return ndvrp_pkg::coord_t'(18'sh1FFFF);
      1: return ndvrp_pkg::coord_t'(18'sh20000);
      2: return ndvrp_pkg::coord_t'($urandom_range(0, 65535) - 32768);
      default: return ndvrp_pkg::coord_t'($urandom);
    endcase
  endfunction

  task automatic queue_vertex(logic cmd, ndvrp_pkg::coord_t fill, bit rnd);
    vertex_t vx;
    vx.cmd = cmd;
    for (int i = 0; i < ndvrp_pkg::NUM_COORDS; i++) vx.c[i] = rnd ? rand_coord() : fill;
    pending_vertices.insert(pending_vertices.size(), vx);
  endtask

  // wait for the pipeline to drain, then let its tail settle
  task automatic drain();
    while (pending_vertices.size() > 0 || expected_results.size() > 0 || start)
      @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [ndvrp_pkg::CFG_IDX_W-1:0] idx,
                           logic [ndvrp_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ndvrp_pkg::REG_DIM:  dim_reg  = val[ndvrp_pkg::DIM_W-1:0];
      ndvrp_pkg::REG_COS:  cos_reg  = val;
      ndvrp_pkg::REG_SIN:  sin_reg  = val;
      ndvrp_pkg::REG_BASE: base_reg = val[ndvrp_pkg::BASE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(int dim, int cv, int sv, int base);
    write_reg(ndvrp_pkg::REG_DIM, ndvrp_pkg::CFG_W'(dim));
    write_reg(ndvrp_pkg::REG_COS, ndvrp_pkg::CFG_W'(cv));
    write_reg(ndvrp_pkg::REG_SIN, ndvrp_pkg::CFG_W'(sv));
    write_reg(ndvrp_pkg::REG_BASE, ndvrp_pkg::CFG_W'(base));
  endtask

  initial begin
    vertex_t vx;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings, extremes of every coordinate, both commands
    queue_vertex(ndvrp_pkg::CMD_ROTATE, ndvrp_pkg::coord_t'(18'sh1FFFF), 0);
    queue_vertex(ndvrp_pkg::CMD_ROTATE, ndvrp_pkg::coord_t'(18'sh20000), 0);
    queue_vertex(ndvrp_pkg::CMD_PROJECT, ndvrp_pkg::coord_t'(18'sh1FFFF), 0);
    queue_vertex(ndvrp_pkg::CMD_PROJECT, ndvrp_pkg::coord_t'(18'sh20000), 0);
    queue_vertex(ndvrp_pkg::CMD_PROJECT, '0, 0);
    drain();

    // zero denominator at level three: coord_2 cancels the distance exactly
    write_reg(ndvrp_pkg::REG_BASE, ndvrp_pkg::CFG_W'(1));
    vx.cmd = ndvrp_pkg::CMD_PROJECT;
    for (int i = 0; i < ndvrp_pkg::NUM_COORDS; i++) vx.c[i] = ndvrp_pkg::coord_t'(18'sh04000);
    vx.c[2] = ndvrp_pkg::coord_t'(-(3 <<< 14));
    pending_vertices.insert(pending_vertices.size(), vx);
    drain();

    // 45 degrees at full dimension; dimension above the maximum
    set_config(8, 11585, 11585, 1);
    for (int k = 0; k < 6; k++) queue_vertex(k[0], '0, 1);
    queue_vertex(ndvrp_pkg::CMD_ROTATE, ndvrp_pkg::coord_t'(18'sh1FFFF), 0);
    queue_vertex(ndvrp_pkg::CMD_PROJECT, ndvrp_pkg::coord_t'(18'sh20000), 0);
    drain();
    set_config(15, -16384, 16384, 255);
    for (int k = 0; k < 6; k++) queue_vertex(k[0], '0, 1);
    drain();
    // dimensions zero, one and two
    for (int dm = 0; dm <= 2; dm++) begin
      write_reg(ndvrp_pkg::REG_DIM, ndvrp_pkg::CFG_W'(dm));
      for (int k = 0; k < 4; k++) queue_vertex(k[0], '0, 1);
      drain();
    end

    // random phases, each with a fresh configuration
    for (int ph = 0; ph < 10; ph++) begin
      set_config($urandom_range(0, 15), $urandom_range(0, 32768) - 16384,
                 $urandom_range(0, 32768) - 16384, $urandom_range(1, 255));
      for (int k = 0; k < 62; k++) queue_vertex(1'($urandom_range(0, 1)), '0, 1);
      drain();
    end

    if (error_count == 0) begin
      $display("[nd_vertex_rotate_project] OK");
    end else begin
      $display("[nd_vertex_rotate_project] ERROR");
    end
    $finish;
  end

endmodule
